// ===== sv/cme_pkg.sv =====
package cme_pkg;

  localparam int COUNTER_BITS_DEF = 32;
  localparam int CNT_W            = 32;
  localparam int MS_W             = 32;
  localparam int CFG_W            = 16;
  localparam int TIME_W           = 64;
  // counter span plus kept remainder, never wraps
  localparam int SPAN_W           = 33;
  localparam int MS_US_W          = MS_W + 10;
  localparam int IN_W             = CNT_W + MS_W;
  localparam int US_PER_MS        = 1000;

  typedef struct packed {
    logic              done;
    logic [SPAN_W-1:0] quot;
    logic [CFG_W-1:0]  rem;
  } cme_div_res_t;

endpackage

// ===== sv/cme_div.sv =====
module cme_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cme_pkg::SPAN_W-1:0] dividend,
  input  logic [cme_pkg::CFG_W-1:0]  divisor,
  output cme_pkg::cme_div_res_t      res
);
  import cme_pkg::*;

  localparam int STEP_CW = $clog2(SPAN_W);

  logic               busy_r;
  logic               done_r;
  logic [STEP_CW-1:0] cnt_r;
  logic [SPAN_W-1:0]  quot_r;
  logic [CFG_W-1:0]   rem_r;
  logic [CFG_W-1:0]   div_r;

  logic [CFG_W:0]     trial;
  logic               fits;
  logic [CFG_W-1:0]   rem_nxt;

  // one quotient bit per cycle: shift the next dividend bit into the remainder
  always_comb begin
    trial   = {rem_r, quot_r[SPAN_W-1]};
    fits    = (trial >= {1'b0, div_r});
    rem_nxt = fits ? CFG_W'(trial - {1'b0, div_r}) : trial[CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        quot_r <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
        cnt_r  <= STEP_CW'(SPAN_W - 1);
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[SPAN_W-2:0], fits};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign res = '{done: done_r, quot: quot_r, rem: rem_r};

endmodule

// ===== sv/cycle_counter_microsecond_extender.sv =====
// Turns a free-running cycle counter reading plus a millisecond tick into a
// 64-bit microsecond time that keeps counting across counter wraps. One sample
// is worked on at a time. A seeding sample, or any sample while the cycles per
// microsecond setting is zero (millisecond fallback), goes from the calculate
// state straight to the output state. Every other sample passes through the
// bit-serial divider, which turns the 33-bit cycle span into microseconds one
// quotient bit per cycle. The input opens again in the cycle after the result
// is loaded. The result sits in an output register, so a new sample can be
// accepted while the previous result still waits to be taken. Write the setting
// only while no sample is in flight.
module cycle_counter_microsecond_extender #(
  parameter int COUNTER_BITS = cme_pkg::COUNTER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cme_pkg::CFG_W-1:0]  cfg_data,    // cycles per microsecond
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [cme_pkg::IN_W-1:0]   in_tdata,    // cycle_count[31:0], ms_tick[63:32]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [cme_pkg::TIME_W-1:0] out_tdata    // usec_time[63:0]
);
  import cme_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_OUT
  } state_t;

  state_t                  state_r;
  logic [CFG_W-1:0]        cfg_r;
  logic [TIME_W-1:0]       time_r;
  logic [COUNTER_BITS-1:0] prev_r;
  logic [COUNTER_BITS-1:0] now_r;
  logic [MS_W-1:0]         ms_r;
  logic [CFG_W-1:0]        leftover_r;
  logic                    seeded_r;
  logic [TIME_W-1:0]       res_r;
  logic                    out_tvalid_r;
  logic [TIME_W-1:0]       out_tdata_r;

  logic [MS_US_W-1:0]      ms_us;
  logic [COUNTER_BITS-1:0] delta;
  logic [SPAN_W-1:0]       span;
  logic                    div_start;
  logic [TIME_W-1:0]       time_sum;
  cme_div_res_t            div_res;

  always_comb begin
    ms_us     = MS_US_W'(ms_r) * MS_US_W'(US_PER_MS);
    delta     = now_r - prev_r;
    span      = SPAN_W'(delta) + SPAN_W'(leftover_r);
    div_start = (state_r == S_CALC) && (cfg_r != '0) && seeded_r;
    time_sum  = time_r + TIME_W'(div_res.quot);
  end

  cme_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (span),
    .divisor  (cfg_r),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_r        <= '0;
      time_r       <= '0;
      prev_r       <= '0;
      leftover_r   <= '0;
      seeded_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      // load a finished result, or drop the one taken this cycle
      if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= res_r;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            now_r   <= in_tdata[COUNTER_BITS-1:0];
            ms_r    <= in_tdata[IN_W-1:CNT_W];
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (cfg_r == '0) begin
            // fallback: report the tick, leave state alone
            res_r   <= TIME_W'(ms_us);
            state_r <= S_OUT;
          end else if (!seeded_r) begin
            seeded_r <= 1'b1;
            prev_r   <= now_r;
            time_r   <= TIME_W'(ms_us);
            res_r    <= TIME_W'(ms_us);
            state_r  <= S_OUT;
          end else begin
            prev_r  <= now_r;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            time_r     <= time_sum;
            res_r      <= time_sum;
            leftover_r <= div_res.rem;
            state_r    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // one sample in flight: no second acceptance right after the first
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sample accepted while previous one still in flight");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_leftover_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && div_res.done |=> leftover_r < cfg_r)
    else $error("kept remainder not below the divisor setting");

  a_div_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> state_r == S_DIV && !div_res.done)
    else $error("divider start without entering divide state");

endmodule

// ===== tb/timebase_checker.sv =====
module timebase_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [cme_pkg::CFG_W-1:0]  cfg_data,    // cycles per microsecond
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [cme_pkg::IN_W-1:0]   in_tdata,    // cycle_count[31:0], ms_tick[63:32]
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [cme_pkg::TIME_W-1:0] out_tdata,   // usec_time[63:0]
  output int                         err_count,
  output int                         n_samples,
  output int                         n_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import cme_pkg::*;

  // shadow of the block's setting and timebase state
  logic [CFG_W-1:0]  cyc_per_us;
  logic [TIME_W-1:0] acc_us;
  logic [CNT_W-1:0]  last_count;
  logic [CFG_W-1:0]  carry_cycles;
  logic              is_seeded;

  logic [TIME_W-1:0] expected_us[$];
  logic [TIME_W-1:0] want_us;
  int                mismatches;

  function automatic logic [TIME_W-1:0] predict_elapsed(input logic [CNT_W-1:0] now,
                                                        input logic [MS_W-1:0]  ms);
    logic [TIME_W-1:0] ms_us;
    logic [CNT_W-1:0]  diff;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] divisor;
    ms_us = TIME_W'(ms) * TIME_W'(US_PER_MS);
    // millisecond fallback leaves the state alone
    if (cyc_per_us == '0) return ms_us;
    if (!is_seeded) begin
      is_seeded  = 1'b1;
      last_count = now;
      acc_us     = ms_us;
    end else begin
      diff         = now - last_count;
      span         = SPAN_W'(diff) + SPAN_W'(carry_cycles);
      divisor      = SPAN_W'(cyc_per_us);
      last_count   = now;
      acc_us       = acc_us + TIME_W'(span / divisor);
      carry_cycles = CFG_W'(span % divisor);
    end
    return acc_us;
  endfunction

  task automatic log_mismatch(input bit orphan, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan)
        $display("unexpected result %h at %0t, nothing pending", got, $realtime);
      else
        $display("usec_time mismatch at result %0d: expected %h, got %h",
                 n_results, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cyc_per_us   = '0;
      acc_us       = '0;
      last_count   = '0;
      carry_cycles = '0;
      is_seeded    = 1'b0;
      mismatches   = 0;
      expected_us.delete();
      err_count <= 0;
      n_samples <= 0;
      n_results <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cyc_per_us = cfg_data;
      if (out_tvalid && out_tready) begin
        if (expected_us.size() == 0) begin
          log_mismatch(1'b1, '0, out_tdata);
        end else begin
          want_us = expected_us.pop_front();
          if (want_us !== out_tdata) log_mismatch(1'b0, want_us, out_tdata);
        end
        n_results <= n_results + 1;
      end
      if (in_tvalid && in_tready) begin
        expected_us.push_back(predict_elapsed(in_tdata[CNT_W-1:0], in_tdata[IN_W-1:CNT_W]));
        n_samples <= n_samples + 1;
      end
      err_count <= mismatches;
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cme_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE_TICKS = 60;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 94;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;    // cycle_count[31:0], ms_tick[63:32]
  logic                out_tvalid;
  logic                out_tready;
  logic [TIME_W-1:0]   out_tdata;   // usec_time[63:0]

  int                  err_count;
  int                  n_samples;
  int                  n_results;

  logic                calm;
  int                  stall_left;
  int                  quiet_ticks;
  logic [CNT_W-1:0]    cnt;
  logic [MS_W-1:0]     ms;
  int                  setting;

  cycle_counter_microsecond_extender dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  timebase_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .err_count  (err_count),
    .n_samples  (n_samples),
    .n_results  (n_results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (calm || stall_left == 0) begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(1, 3);
    end else begin
      out_tready <= 1'b0;
      stall_left--;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_ticks = 0;
    else
      quiet_ticks++;
    if (quiet_ticks >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // call at a rising edge; returns at the edge that takes the transaction
  task automatic send_sample(input logic [CNT_W-1:0] c, input logic [MS_W-1:0] m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {m, c};
    do @(posedge clk); while (!in_tready);
  endtask

  // drain everything in flight, then write the setting
  task automatic write_setting(input int v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_samples != n_results) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    setting = v;
  endtask

  initial begin
    int r;
    logic [CNT_W-1:0] delta;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    calm      = 1'b0;
    setting   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // fallback out of reset, no seeding yet
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample($urandom(), 32'd5);

    // seed with the largest tick, then wrap the counter and take the widest span
    write_setting(1);
    send_sample(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_sample(32'h0000_0010, 32'd7);
    send_sample(32'h0000_0010, 32'd7);
    send_sample(32'h0000_000F, 32'd8);

    // largest setting: build up a remainder, then a span past 32 bits
    write_setting(65535);
    send_sample(32'h0000_000F + 32'd65534, 32'd9);
    send_sample(32'h0000_000F + 32'd65533, 32'd10);
    send_sample(32'h0000_0010 + 32'd65533, 32'd11);

    // smaller setting, same count again: a zero span with nothing kept
    write_setting(3);
    send_sample(32'h0000_0010 + 32'd65533, 32'd12);

    // fallback with seeded state, state must hold
    write_setting(0);
    send_sample(32'hA5A5_5A5A, 32'h0000_0000);
    send_sample(32'h5A5A_A5A5, 32'hFFFF_FFFF);
    write_setting(7);
    send_sample(32'h0001_0000, 32'd13);

    cnt = 32'h0001_0000;
    ms  = 32'd13;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 6)
        0: r = $urandom_range(1, 64);
        1: r = 65535;
        2: r = 0;
        3: r = $urandom_range(1, 65535);
        4: r = 1;
        default: r = $urandom_range(100, 1000);
      endcase
      write_setting(r);
      calm <= (ph == 3 || ph == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 40)      delta = $urandom_range(0, 4 * setting + 8);
        else if (r < 65) delta = $urandom_range(0, 1 << 20);
        else if (r < 85) delta = $urandom();
        else if (r < 93) delta = '0;
        else             delta = 32'hFFFF_FFFF - $urandom_range(0, 15);
        cnt = cnt + delta;
        if ($urandom_range(0, 19) == 0) ms = $urandom();
        else                            ms = ms + $urandom_range(0, 2);
        send_sample(cnt, ms);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_samples != n_results) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
